// ----- rtl/isl_pkg.sv -----
`timescale 1ns / 1ps

package isl_pkg;

	localparam int POS_W    = 6;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = 7;
	localparam int STATUS_W = 2;

	// Request kinds as they arrive on the req_type field.
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ISL_OP_HOLD,
		ISL_OP_INSERT,
		ISL_OP_DELETE
	} isl_op_t;

	typedef struct packed {
		logic                    req_type;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] new_value;
	} isl_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [CNT_W-1:0]        element_count;
		logic                    is_empty;
		logic                    is_full;
		logic signed [VAL_W-1:0] removed_value;
	} isl_rsp_t;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		isl_op_t                 op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} isl_ctl_t;

endpackage

// ----- rtl/isl_cell.sv -----
`timescale 1ns / 1ps

module isl_cell #(
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  isl_pkg::isl_ctl_t                ctl,
	input  logic signed [isl_pkg::VAL_W-1:0] left_val,
	input  logic signed [isl_pkg::VAL_W-1:0] right_val,
	output logic signed [isl_pkg::VAL_W-1:0] val
);

	logic signed [isl_pkg::VAL_W-1:0] val_q;
	int                               pos_i;

	assign pos_i = int'(ctl.pos);
	assign val   = val_q;

	// An insert moves entries above the position up and drops the new word in
	// at the position; a delete pulls every entry from the position onward
	// down by one.
	always_ff @(posedge clk) begin
		case (ctl.op)
			isl_pkg::ISL_OP_INSERT: begin
				if (IDX > pos_i) begin
					val_q <= left_val;
				end else if (IDX == pos_i) begin
					val_q <= ctl.value;
				end
			end
			isl_pkg::ISL_OP_DELETE: begin
				if (IDX >= pos_i) begin
					val_q <= right_val;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/indexed_shift_list.sv -----
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit words with insert and delete at an
// index. A request enters on req when req_valid is high and req_stall is low.
// An insert places new_value at position and moves every later entry up one
// place; a delete removes the entry at position, moves later entries down one
// place and returns the removed word. Each request yields exactly one result
// on rsp, qualified by rsp_valid and taken when rsp_stall is low. The result
// carries a status, the element count after the request, empty and full flags
// and the removed word (zero unless a delete succeeded).
// rsp_valid rises in the cycle after acceptance, and one request is taken
// every cycle while no result is held: the whole row of storage cells shifts
// together, and the result sits in one output register.
// When the receiver stalls, the held result stays put and req_stall rises, so
// no further request is taken until the result leaves.
// Reset empties the list and clears rsp_valid; cell contents are not cleared,
// since only entries below the count are ever read.
module indexed_shift_list #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  isl_pkg::isl_req_t req,
	input  logic              req_valid,
	output logic              req_stall,
	output isl_pkg::isl_rsp_t rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int XW   = CW + isl_pkg::POS_W;
	localparam int NSEL = (DEPTH < (1 << isl_pkg::POS_W)) ? DEPTH : (1 << isl_pkg::POS_W);

	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    count_next;
	logic                             rsp_valid_q;
	isl_pkg::isl_rsp_t                rsp_q;
	isl_pkg::isl_rsp_t                rsp_d;
	isl_pkg::isl_ctl_t                ctl;
	logic                             accept;
	logic                             is_full_now;
	logic                             ins_ok;
	logic                             del_ok;
	logic [XW-1:0]                    pos_x;
	logic [XW-1:0]                    cnt_x;
	logic [CW+isl_pkg::CNT_W-1:0]     cnt_wide;
	logic signed [isl_pkg::VAL_W-1:0] sel_val;
	logic signed [isl_pkg::VAL_W-1:0] cell_val [DEPTH];

	// A new request is taken whenever the output register is free or its
	// result is leaving in the same cycle.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign pos_x       = XW'(req.position);
	assign cnt_x       = XW'(count_q);
	assign is_full_now = (count_q == CW'(DEPTH));

	// The full check comes first for inserts; an insert may land at the end,
	// a delete must hit an existing entry.
	assign ins_ok = (req.req_type == isl_pkg::REQ_INSERT) && !is_full_now && (pos_x <= cnt_x);
	assign del_ok = (req.req_type == isl_pkg::REQ_DELETE) && (pos_x < cnt_x);

	always_comb begin
		ctl.pos   = req.position;
		ctl.value = req.new_value;
		ctl.op    = isl_pkg::ISL_OP_HOLD;
		if (accept && ins_ok) begin
			ctl.op = isl_pkg::ISL_OP_INSERT;
		end else if (accept && del_ok) begin
			ctl.op = isl_pkg::ISL_OP_DELETE;
		end
	end

	// The row of cells. Each cell takes its lower neighbor on an insert and
	// its upper neighbor on a delete; the ends see zero.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [isl_pkg::VAL_W-1:0] left_v;
		logic signed [isl_pkg::VAL_W-1:0] right_v;

		if (g == 0) begin : g_head
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end

		isl_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.left_val (left_v),
			.right_val(right_v),
			.val      (cell_val[g])
		);
	end

	// Pick the word that a delete removes. Positions beyond the row never
	// pass the range check, so only the first cells need a look.
	always_comb begin
		sel_val = '0;
		for (int i = 0; i < NSEL; i++) begin
			if (req.position == isl_pkg::POS_W'(i)) begin
				sel_val = cell_val[i];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + CW'(1);
		end else if (del_ok) begin
			count_next = count_q - CW'(1);
		end
	end

	assign cnt_wide = (CW + isl_pkg::CNT_W)'(count_next);

	always_comb begin
		rsp_d.element_count = cnt_wide[isl_pkg::CNT_W-1:0];
		rsp_d.is_empty      = (count_next == '0);
		rsp_d.is_full       = (count_next == CW'(DEPTH));
		rsp_d.removed_value = del_ok ? sel_val : '0;
		if (ins_ok || del_ok) begin
			rsp_d.status = isl_pkg::ST_DONE;
		end else if ((req.req_type == isl_pkg::REQ_INSERT) && is_full_now) begin
			rsp_d.status = isl_pkg::ST_FULL;
		end else begin
			rsp_d.status = isl_pkg::ST_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// The count never passes the capacity of the row.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list count exceeds depth");

	// An accepted request always shows a result in the next cycle.
	a_accept_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted request produced no result");

	// A rejected request never returns a removed word.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != isl_pkg::ST_DONE) |-> (rsp.removed_value == '0))
		else $error("rejected request returned a value");

	// The count only moves when a request is taken, by at most one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without a request");

endmodule

// ----- sim/tb_indexed_shift_list.sv -----
`timescale 1ns / 1ps

module tb_indexed_shift_list;

	localparam int DEPTH      = 64;
	localparam int STALL_LIMIT = 4000;
	localparam int RAND_ITEMS = 1000;

	typedef struct {
		bit                 pause;
		int                 phase;
		isl_pkg::isl_req_t  req;
	} pending_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	isl_pkg::isl_req_t req = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	isl_pkg::isl_rsp_t rsp;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;

	// Percent of cycles in which each side holds off, one entry per phase.
	int sender_idle_pct [4] = '{0, 84, 0, 9};
	int receiver_stall_pct [4] = '{0, 0, 84, 9};

	pending_req_t      pending_reqs[$];
	isl_pkg::isl_rsp_t expected_rsp[$];
	int                cur_phase = 0;
	int                errors = 0;
	int                idle_cycles = 0;
	int                gen_count = 0;

	// Shadow copy of the list used to predict each result.
	logic signed [isl_pkg::VAL_W-1:0] shadow_cells [DEPTH];
	int                               shadow_count = 0;

	indexed_shift_list #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic isl_pkg::isl_rsp_t apply_list_request(isl_pkg::isl_req_t r);
		isl_pkg::isl_rsp_t o;
		int                p;
		int                k;
		o = '0;
		p = int'(r.position);
		if (r.req_type == isl_pkg::REQ_INSERT) begin
			if (shadow_count >= DEPTH) begin
				o.status = isl_pkg::ST_FULL;
			end else if (p > shadow_count) begin
				o.status = isl_pkg::ST_RANGE;
			end else begin
				for (k = shadow_count; k > p; k--)
					shadow_cells[k] = shadow_cells[k-1];
				shadow_cells[p] = r.new_value;
				shadow_count++;
				o.status = isl_pkg::ST_DONE;
			end
		end else begin
			if (p >= shadow_count) begin
				o.status = isl_pkg::ST_RANGE;
			end else begin
				o.removed_value = shadow_cells[p];
				for (k = p; k + 1 < shadow_count; k++)
					shadow_cells[k] = shadow_cells[k+1];
				shadow_count--;
				o.status = isl_pkg::ST_DONE;
			end
		end
		o.element_count = shadow_count[isl_pkg::CNT_W-1:0];
		o.is_empty = (shadow_count == 0);
		o.is_full = (shadow_count == DEPTH);
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// The generator keeps its own count so it can aim positions at the live range.
	task automatic queue_request(logic kind, int pos, logic [31:0] val, int ph);
		pending_req_t it;
		it.pause = 1'b0;
		it.phase = ph;
		it.req.req_type = kind;
		it.req.position = pos[isl_pkg::POS_W-1:0];
		it.req.new_value = val;
		pending_reqs.push_back(it);
		if (kind == isl_pkg::REQ_INSERT) begin
			if (gen_count < DEPTH && pos <= gen_count)
				gen_count++;
		end else if (pos < gen_count) begin
			gen_count--;
		end
	endtask

	// A pause marker holds the sender until every outstanding result is back.
	task automatic queue_pause(int ph);
		pending_req_t it;
		it.pause = 1'b1;
		it.phase = ph;
		it.req = '0;
		pending_reqs.push_back(it);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Driver: presents the next request only when nothing is being held.
	always @(posedge clk) begin
		logic              take;
		logic              nv;
		isl_pkg::isl_req_t np;
		pending_req_t      it;
		if (arst_n) begin
			take = req_valid && !req_stall;
			nv = req_valid && !take;
			np = req;
			if (!nv && pending_reqs.size() != 0) begin
				cur_phase = pending_reqs[0].phase;
				if (pending_reqs[0].pause) begin
					if (!take && expected_rsp.size() == 0 && !rsp_valid)
						it = pending_reqs.pop_front();
				end else if ($urandom_range(99) >= sender_idle_pct[cur_phase]) begin
					it = pending_reqs.pop_front();
					nv = 1'b1;
					np = it.req;
				end
			end
			req_valid <= nv;
			req <= np;
			rsp_stall <= ($urandom_range(99) < receiver_stall_pct[cur_phase]);
		end
	end

	// Monitor: checks each accepted result, then predicts for each accepted request.
	always @(posedge clk) begin
		isl_pkg::isl_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("result with none expected",
						32'(rsp.removed_value), 32'h0);
				end else begin
					want = expected_rsp.pop_front();
					check_field("status", 32'(rsp.status), 32'(want.status));
					check_field("element_count", 32'(rsp.element_count),
						32'(want.element_count));
					check_field("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
					check_field("is_full", 32'(rsp.is_full), 32'(want.is_full));
					check_field("removed_value", 32'(rsp.removed_value),
						32'(want.removed_value));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(apply_list_request(req));
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int i;
		int ph;
		int mode;
		int ins_pct;
		int r;
		int pos;
		logic kind;

		// Rejections on an empty list, including a delete with a nonzero value.
		queue_request(isl_pkg::REQ_DELETE, 0, 32'h1234_5678, 0);
		queue_request(isl_pkg::REQ_DELETE, 63, 32'h0, 0);
		queue_request(isl_pkg::REQ_INSERT, 1, 32'h1, 0);
		queue_request(isl_pkg::REQ_INSERT, 63, 32'h2, 0);
		// Build a short list with inserts at head, tail and middle.
		queue_request(isl_pkg::REQ_INSERT, 0, 32'h7FFF_FFFF, 0);
		queue_request(isl_pkg::REQ_INSERT, 1, 32'h8000_0000, 0);
		queue_request(isl_pkg::REQ_INSERT, 0, 32'hFFFF_FFFF, 0);
		queue_request(isl_pkg::REQ_INSERT, 1, 32'h0, 0);
		queue_request(isl_pkg::REQ_INSERT, 2, 32'h5555_5555, 0);
		queue_request(isl_pkg::REQ_INSERT, 6, 32'h3, 0);
		queue_request(isl_pkg::REQ_INSERT, 5, 32'hAAAA_AAAA, 0);
		// Deletes at and past the end, then middle, tail and head.
		queue_request(isl_pkg::REQ_DELETE, 6, 32'h0, 0);
		queue_request(isl_pkg::REQ_DELETE, 63, 32'h0, 0);
		queue_request(isl_pkg::REQ_DELETE, 2, 32'hFFFF_FFFF, 0);
		queue_request(isl_pkg::REQ_DELETE, 4, 32'h0, 0);
		queue_request(isl_pkg::REQ_DELETE, 0, 32'h0, 0);
		queue_request(isl_pkg::REQ_DELETE, 0, 32'h0, 0);
		queue_request(isl_pkg::REQ_DELETE, 0, 32'h0, 0);
		queue_request(isl_pkg::REQ_DELETE, 0, 32'h0, 0);
		queue_request(isl_pkg::REQ_DELETE, 0, 32'h0, 0);
		queue_request(isl_pkg::REQ_INSERT, 0, 32'h1, 0);
		queue_pause(0);

		// Random part: stretches that fill the list to full, mix, and drain it.
		for (i = 0; i < RAND_ITEMS; i++) begin
			ph = i / (RAND_ITEMS / 4);
			mode = (i / 125) % 4;
			ins_pct = (mode == 0) ? 85 : (mode == 2) ? 15 : 50;
			kind = ($urandom_range(99) < ins_pct) ? isl_pkg::REQ_INSERT
				: isl_pkg::REQ_DELETE;
			r = $urandom_range(99);
			if (r < 10 || (kind == isl_pkg::REQ_DELETE && gen_count == 0)) begin
				pos = $urandom_range(63);
			end else if (r < 25) begin
				pos = 0;
			end else if (r < 40) begin
				pos = (kind == isl_pkg::REQ_INSERT) ? gen_count : gen_count - 1;
			end else if (kind == isl_pkg::REQ_INSERT) begin
				pos = $urandom_range(gen_count);
			end else begin
				pos = $urandom_range(gen_count - 1);
			end
			if (pos > 63)
				pos = 63;
			queue_request(kind, pos, pick_value(), ph);
			if (i == RAND_ITEMS / 2)
				queue_pause(ph);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (idle_cycles < STALL_LIMIT &&
			(pending_reqs.size() != 0 || req_valid || expected_rsp.size() != 0))
			@(posedge clk);
		if (idle_cycles < STALL_LIMIT)
			repeat (10) @(posedge clk);

		if (idle_cycles < STALL_LIMIT && errors == 0 && expected_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
